// ----- rtl/sexp_tok_pkg.sv -----
// ----------------------------------------------------------------------------
// sexp_tok_pkg
// Shared types, codes and character helpers of the s-expression tokenizer.
// ----------------------------------------------------------------------------
package sexp_tok_pkg;

  localparam int unsigned INT_WIDTH_DEF = 32;
  localparam int unsigned MAX_RES       = 3;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_COMMENT = 4'd1,
    MODE_HASH    = 4'd2,
    MODE_SIGN    = 4'd3,
    MODE_NUM     = 4'd4,
    MODE_DOT     = 4'd5,
    MODE_FRAC    = 4'd6,
    MODE_STR     = 4'd7,
    MODE_ESC     = 4'd8,
    MODE_SYM     = 4'd9,
    MODE_DEAD    = 4'd10
  } lex_mode_t;

  typedef enum logic [1:0] {
    KIND_CHAR = 2'd0,
    KIND_END  = 2'd1,
    KIND_ERR  = 2'd2,
    KIND_EOS  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    TT_OPEN  = 3'd0,
    TT_CLOSE = 3'd1,
    TT_BOOL  = 3'd2,
    TT_INT   = 3'd3,
    TT_FLOAT = 3'd4,
    TT_STR   = 3'd5,
    TT_SYM   = 3'd6
  } tok_type_t;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_BOOL      = 4'd1,
    ERR_DOT2      = 4'd2,
    ERR_NUM_CHAR  = 4'd3,
    ERR_SIGN      = 4'd4,
    ERR_DOT       = 4'd5,
    ERR_FLOAT     = 4'd6,
    ERR_STR       = 4'd7,
    ERR_SYM_END   = 4'd8,
    ERR_ILLEGAL   = 4'd9
  } err_code_t;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;

  // control part of the lexer state
  typedef struct packed {
    lex_mode_t  mode;
    logic       negative;
    logic [7:0] pending_sign;
    logic       seen_dot;
    logic       saturated;
  } lex_ctl_t;

  // one result word, without the last flag
  typedef struct packed {
    kind_t              kind;
    tok_type_t          token_type;
    logic [7:0]         text_char;
    logic               bool_value;
    logic signed [31:0] int_value;
    logic               int_overflow;
    err_code_t          error_code;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_sym_start(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == 8'h21) || (c == 8'h24) || (c == 8'h25) || (c == 8'h26) ||
           (c == 8'h2A) || (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3C) ||
           (c == 8'h3E) || (c == 8'h3D) || (c == 8'h3F) || (c == CH_TILDE) ||
           (c == 8'h5F) || (c == CH_CARET);
  endfunction

  function automatic logic is_sym_more(input logic [7:0] c);
    return is_sym_start(c) || is_digit(c) || (c == CH_DOT) || (c == CH_PLUS) ||
           (c == CH_MINUS);
  endfunction

  function automatic res_t mk_lex(input tok_type_t tt, input logic [7:0] c);
    res_t r;
    r = '0;
    r.kind       = KIND_CHAR;
    r.token_type = tt;
    r.text_char  = c;
    return r;
  endfunction

  function automatic res_t mk_end(input tok_type_t tt);
    res_t r;
    r = '0;
    r.kind       = KIND_END;
    r.token_type = tt;
    return r;
  endfunction

  function automatic res_t mk_err(input err_code_t code);
    res_t r;
    r = '0;
    r.kind       = KIND_ERR;
    r.error_code = code;
    return r;
  endfunction

  function automatic res_t mk_eos();
    res_t r;
    r = '0;
    r.kind = KIND_EOS;
    return r;
  endfunction

endpackage

// ----- rtl/sexp_tok_in_if.sv -----
// ----------------------------------------------------------------------------
// sexp_tok_in_if
// Byte channel into the tokenizer: one source byte or end-of-input mark.
// ----------------------------------------------------------------------------
interface sexp_tok_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       end_of_input;

  modport source (output valid, output char_in, output end_of_input, input ready);
  modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

// ----- rtl/sexp_tok_out_if.sv -----
// ----------------------------------------------------------------------------
// sexp_tok_out_if
// Token event channel out of the tokenizer.
// ----------------------------------------------------------------------------
interface sexp_tok_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [2:0]         token_type;
  logic [7:0]         text_char;
  logic               bool_value;
  logic signed [31:0] int_value;
  logic               int_overflow;
  logic [3:0]         error_code;
  logic               last;

  modport source (output valid, output kind, output token_type, output text_char,
                  output bool_value, output int_value, output int_overflow,
                  output error_code, output last, input ready);
  modport sink   (input valid, input kind, input token_type, input text_char,
                  input bool_value, input int_value, input int_overflow,
                  input error_code, input last, output ready);
endinterface

// ----- rtl/sexp_tok_step.sv -----
// ----------------------------------------------------------------------------
// sexp_tok_step
// Next-state and result logic for one input byte: up to three words out.
// ----------------------------------------------------------------------------
module sexp_tok_step #(
  parameter int unsigned INT_WIDTH = sexp_tok_pkg::INT_WIDTH_DEF
) (
  input  sexp_tok_pkg::lex_ctl_t       ctl,
  input  logic [INT_WIDTH-1:0]         acc,
  input  logic [7:0]                   ch,
  input  logic                         eoi,
  output sexp_tok_pkg::lex_ctl_t       ctl_nxt,
  output logic [INT_WIDTH-1:0]         acc_nxt,
  output logic [1:0]                   n_res,
  output sexp_tok_pkg::res_t [2:0]     res
);

  localparam int unsigned EW = (INT_WIDTH > 32) ? INT_WIDTH : 32;

  logic [3:0]           dig;
  logic [INT_WIDTH+3:0] sum10;
  logic [INT_WIDTH-1:0] lim_w;
  logic                 over;
  logic [INT_WIDTH-1:0] acc_add;
  logic                 sat_add;
  logic [EW-1:0]        acc_ext;
  logic [EW-1:0]        acc_neg;
  sexp_tok_pkg::res_t   int_end;

  // saturating acc * 10 + digit, compared against the signed limit
  always_comb begin
    dig     = ch[3:0];
    sum10   = (INT_WIDTH+4)'({acc, 3'b000}) + (INT_WIDTH+4)'({acc, 1'b0}) +
              (INT_WIDTH+4)'(dig);
    lim_w   = ctl.negative ? {1'b1, {(INT_WIDTH-1){1'b0}}} : {1'b0, {(INT_WIDTH-1){1'b1}}};
    over    = sum10 > (INT_WIDTH+4)'(lim_w);
    acc_add = ctl.saturated ? acc : (over ? lim_w : sum10[INT_WIDTH-1:0]);
    sat_add = ctl.saturated | over;
  end

  always_comb begin
    acc_ext = EW'(acc);
    acc_neg = -acc_ext;
    int_end = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_INT);
    int_end.int_value    = ctl.negative ? acc_neg[31:0] : acc_ext[31:0];
    int_end.int_overflow = ctl.saturated;
  end

  always_comb begin
    logic run_idle;
    logic [1:0] n;
    run_idle = 1'b0;
    n        = 2'd0;
    res      = '0;
    ctl_nxt  = ctl;
    acc_nxt  = acc;

    if (eoi) begin
      unique case (ctl.mode)
        sexp_tok_pkg::MODE_HASH: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_BOOL); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_SIGN: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_SIGN); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_NUM: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_NUM_CHAR); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_DOT: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_DOT); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_FRAC: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_FLOAT); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_STR, sexp_tok_pkg::MODE_ESC: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_STR); n = n + 2'd1;
        end
        sexp_tok_pkg::MODE_SYM: begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_SYM_END); n = n + 2'd1;
        end
        default: begin
        end
      endcase
      res[n] = sexp_tok_pkg::mk_eos();
      n = n + 2'd1;
      ctl_nxt = '0;
      ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
      acc_nxt = '0;
    end else begin
      unique case (ctl.mode)
        sexp_tok_pkg::MODE_IDLE: run_idle = 1'b1;
        sexp_tok_pkg::MODE_COMMENT: begin
          if (ch == sexp_tok_pkg::CH_LF) ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
        end
        sexp_tok_pkg::MODE_HASH: begin
          priority if (ch == 8'h74 || ch == 8'h54) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_BOOL, ch); n = n + 2'd1;
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_BOOL);
            res[n].bool_value = 1'b1;
            n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
          end else if (ch == 8'h66 || ch == 8'h46) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_BOOL, ch); n = n + 2'd1;
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_BOOL); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_BOOL); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        sexp_tok_pkg::MODE_SIGN: begin
          priority if (ch == sexp_tok_pkg::CH_SPACE) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_SYM, ctl.pending_sign);
            n = n + 2'd1;
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_SYM); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
          end else if (sexp_tok_pkg::is_digit(ch)) begin
            if (ctl.negative) begin
              res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_INT, sexp_tok_pkg::CH_MINUS);
              n = n + 2'd1;
            end
            acc_nxt = acc_add;
            ctl_nxt.saturated = sat_add;
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_INT, ch); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_NUM;
          end else if (ch == sexp_tok_pkg::CH_DOT) begin
            if (ctl.negative) begin
              res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_MINUS);
              n = n + 2'd1;
            end
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_ZERO);
            n = n + 2'd1;
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_DOT);
            n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DOT;
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_SIGN); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        sexp_tok_pkg::MODE_NUM: begin
          priority if (sexp_tok_pkg::is_digit(ch)) begin
            if (!ctl.seen_dot) begin
              acc_nxt = acc_add;
              ctl_nxt.saturated = sat_add;
            end
            res[n] = sexp_tok_pkg::mk_lex(ctl.seen_dot ? sexp_tok_pkg::TT_FLOAT :
                                          sexp_tok_pkg::TT_INT, ch);
            n = n + 2'd1;
          end else if (ch == sexp_tok_pkg::CH_DOT) begin
            if (ctl.seen_dot) begin
              res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_DOT2); n = n + 2'd1;
              ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
            end else begin
              ctl_nxt.seen_dot = 1'b1;
              res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, ch); n = n + 2'd1;
            end
          end else if (ch == sexp_tok_pkg::CH_SPACE || ch == sexp_tok_pkg::CH_RPAREN) begin
            res[n] = ctl.seen_dot ? sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_FLOAT) : int_end;
            n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
            run_idle = (ch == sexp_tok_pkg::CH_RPAREN);
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_NUM_CHAR); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        sexp_tok_pkg::MODE_DOT: begin
          if (sexp_tok_pkg::is_digit(ch)) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, ch); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_FRAC;
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_DOT); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        sexp_tok_pkg::MODE_FRAC: begin
          priority if (sexp_tok_pkg::is_digit(ch)) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, ch); n = n + 2'd1;
          end else if (ch == sexp_tok_pkg::CH_SPACE || ch == sexp_tok_pkg::CH_RPAREN) begin
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_FLOAT); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
            run_idle = (ch == sexp_tok_pkg::CH_RPAREN);
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_FLOAT); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        sexp_tok_pkg::MODE_STR: begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_STR, ch); n = n + 2'd1;
          priority if (ch == sexp_tok_pkg::CH_BSLASH) begin
            ctl_nxt.mode = sexp_tok_pkg::MODE_ESC;
          end else if (ch == sexp_tok_pkg::CH_QUOTE) begin
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_STR); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
          end else begin
          end
        end
        sexp_tok_pkg::MODE_ESC: begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_STR, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_STR;
        end
        sexp_tok_pkg::MODE_SYM: begin
          priority if (sexp_tok_pkg::is_sym_more(ch)) begin
            res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_SYM, ch); n = n + 2'd1;
          end else if (ch == sexp_tok_pkg::CH_SPACE || ch == sexp_tok_pkg::CH_LPAREN ||
                       ch == sexp_tok_pkg::CH_RPAREN) begin
            res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_SYM); n = n + 2'd1;
            run_idle = 1'b1;
          end else begin
            res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_SYM_END); n = n + 2'd1;
            ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
          end
        end
        default: begin
        end
      endcase

      // a byte seen from idle, also the delimiter that closed a token
      if (run_idle) begin
        ctl_nxt.mode = sexp_tok_pkg::MODE_IDLE;
        priority if (ch == sexp_tok_pkg::CH_LPAREN) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_OPEN, ch); n = n + 2'd1;
          res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_OPEN); n = n + 2'd1;
        end else if (ch == sexp_tok_pkg::CH_RPAREN) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_CLOSE, ch); n = n + 2'd1;
          res[n] = sexp_tok_pkg::mk_end(sexp_tok_pkg::TT_CLOSE); n = n + 2'd1;
        end else if (ch == sexp_tok_pkg::CH_SEMI) begin
          ctl_nxt.mode = sexp_tok_pkg::MODE_COMMENT;
        end else if (ch == sexp_tok_pkg::CH_HASH) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_BOOL, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_HASH;
        end else if (sexp_tok_pkg::is_digit(ch)) begin
          ctl_nxt.negative  = 1'b0;
          ctl_nxt.seen_dot  = 1'b0;
          ctl_nxt.saturated = 1'b0;
          acc_nxt = INT_WIDTH'(dig);
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_INT, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_NUM;
        end else if (ch == sexp_tok_pkg::CH_PLUS || ch == sexp_tok_pkg::CH_MINUS) begin
          ctl_nxt.pending_sign = ch;
          ctl_nxt.negative     = (ch == sexp_tok_pkg::CH_MINUS);
          ctl_nxt.seen_dot     = 1'b0;
          ctl_nxt.saturated    = 1'b0;
          acc_nxt = '0;
          ctl_nxt.mode = sexp_tok_pkg::MODE_SIGN;
        end else if (ch == sexp_tok_pkg::CH_DOT) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_ZERO);
          n = n + 2'd1;
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_FLOAT, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_DOT;
        end else if (ch == sexp_tok_pkg::CH_QUOTE) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_STR, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_STR;
        end else if (ch == sexp_tok_pkg::CH_SPACE || ch == sexp_tok_pkg::CH_LF ||
                     ch == sexp_tok_pkg::CH_TAB) begin
        end else if (sexp_tok_pkg::is_sym_start(ch)) begin
          res[n] = sexp_tok_pkg::mk_lex(sexp_tok_pkg::TT_SYM, ch); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_SYM;
        end else begin
          res[n] = sexp_tok_pkg::mk_err(sexp_tok_pkg::ERR_ILLEGAL); n = n + 2'd1;
          ctl_nxt.mode = sexp_tok_pkg::MODE_DEAD;
        end
      end
    end
    n_res = n;
  end

endmodule

// ----- rtl/s_expression_tokenizer_core.sv -----
// ----------------------------------------------------------------------------
// s_expression_tokenizer_core
// Streaming s-expression lexer: one source byte in, token event words out.
// ----------------------------------------------------------------------------
// in_chan carries one source byte per word, or an end-of-input mark.
// out_chan carries token events: lexeme characters, token ends with bool or
// integer value, the first syntax error, and end of stream. last flags the
// final word caused by one input word; a byte may cause none.
// The first word of a byte appears on out_chan the cycle after the byte is
// taken. One byte per cycle is taken while each byte gives at most one word
// and out_chan keeps up; a byte that gives two or three words holds
// in_chan.ready low until the three-entry result buffer, drained one word
// per cycle while out_chan is ready, is down to its last word being taken.
// Integers are accumulated with a shift-add by ten and a compare against the
// signed limit in the same cycle, saturating at INT_WIDTH bits.
// Reset clears the lexer to idle and empties the result buffer.
// When out_chan stalls, the buffered words hold and no byte is taken until
// the buffer is down to its last word being taken.
// After end of input the lexer returns to its reset state.
module s_expression_tokenizer_core #(
  parameter int unsigned INT_WIDTH = sexp_tok_pkg::INT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sexp_tok_in_if.sink           in_chan,
  sexp_tok_out_if.source        out_chan
);

  sexp_tok_pkg::lex_ctl_t       ctl_r, ctl_nxt;
  logic [INT_WIDTH-1:0]         acc_r, acc_nxt;
  sexp_tok_pkg::res_t [2:0]     res_r;
  sexp_tok_pkg::res_t [2:0]     step_res;
  logic [1:0]                   cnt_r;
  logic [1:0]                   step_n;
  logic                         in_acc;
  logic                         out_acc;

  sexp_tok_step #(
    .INT_WIDTH (INT_WIDTH)
  ) u_step (
    .ctl     (ctl_r),
    .acc     (acc_r),
    .ch      (in_chan.char_in),
    .eoi     (in_chan.end_of_input),
    .ctl_nxt (ctl_nxt),
    .acc_nxt (acc_nxt),
    .n_res   (step_n),
    .res     (step_res)
  );

  // take a byte once the buffer is empty or its last word leaves now
  assign in_chan.ready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_chan.ready);
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // idle is the all-zero mode
      ctl_r      <= '0;
      acc_r      <= '0;
      cnt_r      <= 2'd0;
    end else begin
      if (in_acc) begin
        ctl_r <= ctl_nxt;
        acc_r <= acc_nxt;
        cnt_r <= step_n;
      end else if (out_acc) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= step_res;
    end else if (out_acc) begin
      res_r[0] <= res_r[1];
      res_r[1] <= res_r[2];
    end
  end

  assign out_chan.valid        = (cnt_r != 2'd0);
  assign out_chan.kind         = res_r[0].kind;
  assign out_chan.token_type   = res_r[0].token_type;
  assign out_chan.text_char    = res_r[0].text_char;
  assign out_chan.bool_value   = res_r[0].bool_value;
  assign out_chan.int_value    = res_r[0].int_value;
  assign out_chan.int_overflow = res_r[0].int_overflow;
  assign out_chan.error_code   = res_r[0].error_code;
  assign out_chan.last         = (cnt_r == 2'd1);

  a_eoi_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_chan.end_of_input) |=> (ctl_r.mode == sexp_tok_pkg::MODE_IDLE))
    else $error("lexer not idle after end of input");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (cnt_r == $past(cnt_r)))
    else $error("buffered words changed during stall");

  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |->
      ((out_chan.kind == sexp_tok_pkg::KIND_ERR) ==
       (out_chan.error_code != sexp_tok_pkg::ERR_NONE)))
    else $error("error code and word kind disagree");

  a_eos_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.kind == sexp_tok_pkg::KIND_EOS) |-> out_chan.last)
    else $error("end of stream not the last word");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_r.saturated |-> (acc_r[INT_WIDTH-2:0] == (ctl_r.negative ?
      {(INT_WIDTH-1){1'b0}} : {(INT_WIDTH-1){1'b1}})))
    else $error("saturated accumulator off its limit");

endmodule

// ----- verif/s_expression_tokenizer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s_expression_tokenizer_core_tb
// Feeds source bytes and end-of-input marks into the tokenizer. A software
// lexer predicts every token event word, and each word taken from the block
// is checked field by field against it. A short hand-written stream opens
// the run. Random token streams follow, mostly well formed with some broken
// and noisy input, while both channels idle and stall at random until a final quiet stretch.
// ----------------------------------------------------------------------------
module s_expression_tokenizer_core_tb;

  typedef struct packed {
    logic       eoi;
    logic [7:0] c;
  } src_word_t;

  typedef struct {
    sexp_tok_pkg::kind_t     kind;
    sexp_tok_pkg::tok_type_t tt;
    logic [7:0]              ch;
    logic                    bv;
    logic [31:0]             iv;
    logic                    ov;
    sexp_tok_pkg::err_code_t err;
    logic                    last;
  } tok_word_t;

  logic clk = 1'b0;
  logic rst_n;

  sexp_tok_in_if  in_if();
  sexp_tok_out_if out_if();

  s_expression_tokenizer_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_if),
    .out_chan(out_if)
  );

  src_word_t source_bytes[$];
  tok_word_t expected_events[$];
  tok_word_t step_words[$];

  int queued_items;
  int fail_count;
  int words_seen;
  int send_gap;
  int recv_stall;
  int long_hold_left;
  bit long_hold_done;
  bit quiet;

  // lexer state mirrored by the predictor
  sexp_tok_pkg::lex_mode_t pm_mode;
  logic        pm_neg;
  logic [7:0]  pm_sign;
  logic        pm_dot;
  logic [63:0] pm_acc;
  logic        pm_sat;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_in = 8'h00;
    in_if.end_of_input = 1'b0;
    out_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic digit_char(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic sym_head(logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], "!", "$", "%", "&", "*", "/", ":",
                     "<", ">", "=", "?", "_", sexp_tok_pkg::CH_TILDE,
                     sexp_tok_pkg::CH_CARET};
  endfunction

  function automatic logic sym_tail(logic [7:0] c);
    return sym_head(c) || digit_char(c) ||
           c inside {sexp_tok_pkg::CH_DOT, sexp_tok_pkg::CH_PLUS, sexp_tok_pkg::CH_MINUS};
  endfunction

  function automatic void emit_word(sexp_tok_pkg::kind_t k, sexp_tok_pkg::tok_type_t t,
                                    logic [7:0] ch, logic bv, logic [31:0] iv, logic ov,
                                    sexp_tok_pkg::err_code_t e);
    tok_word_t w;
    w.kind = k;
    w.tt   = t;
    w.ch   = ch;
    w.bv   = bv;
    w.iv   = iv;
    w.ov   = ov;
    w.err  = e;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void put_char(sexp_tok_pkg::tok_type_t t, logic [7:0] c);
    emit_word(sexp_tok_pkg::KIND_CHAR, t, c, 1'b0, 32'h0, 1'b0, sexp_tok_pkg::ERR_NONE);
  endfunction

  function automatic void put_end(sexp_tok_pkg::tok_type_t t);
    emit_word(sexp_tok_pkg::KIND_END, t, 8'h00, 1'b0, 32'h0, 1'b0, sexp_tok_pkg::ERR_NONE);
  endfunction

  function automatic void raise_err(sexp_tok_pkg::err_code_t e);
    emit_word(sexp_tok_pkg::KIND_ERR, sexp_tok_pkg::TT_OPEN, 8'h00, 1'b0, 32'h0, 1'b0, e);
    pm_mode = sexp_tok_pkg::MODE_DEAD;
  endfunction

  function automatic void clear_lexer();
    pm_mode = sexp_tok_pkg::MODE_IDLE;
    pm_neg  = 1'b0;
    pm_sign = 8'h00;
    pm_dot  = 1'b0;
    pm_acc  = 64'h0;
    pm_sat  = 1'b0;
  endfunction

  // magnitude limit is 2^31 - 1, or 2^31 for a negative number
  function automatic void acc_digit(logic [7:0] c);
    logic [63:0] d;
    logic [63:0] lim;
    d = 64'(c) - 64'(sexp_tok_pkg::CH_ZERO);
    lim = 64'd1 << 31;
    if (!pm_neg) lim = lim - 64'd1;
    if (pm_sat) return;
    if (pm_acc > (lim - d) / 64'd10) begin
      pm_acc = lim;
      pm_sat = 1'b1;
    end else begin
      pm_acc = pm_acc * 64'd10 + d;
    end
  endfunction

  function automatic void close_number();
    logic [63:0] v;
    if (pm_dot) begin
      put_end(sexp_tok_pkg::TT_FLOAT);
    end else begin
      v = pm_neg ? 64'h0 - pm_acc : pm_acc;
      emit_word(sexp_tok_pkg::KIND_END, sexp_tok_pkg::TT_INT, 8'h00, 1'b0, v[31:0], pm_sat,
                sexp_tok_pkg::ERR_NONE);
    end
    pm_mode = sexp_tok_pkg::MODE_IDLE;
  endfunction

  function automatic void idle_byte(logic [7:0] c);
    pm_mode = sexp_tok_pkg::MODE_IDLE;
    if (c == sexp_tok_pkg::CH_LPAREN) begin
      put_char(sexp_tok_pkg::TT_OPEN, c);
      put_end(sexp_tok_pkg::TT_OPEN);
    end else if (c == sexp_tok_pkg::CH_RPAREN) begin
      put_char(sexp_tok_pkg::TT_CLOSE, c);
      put_end(sexp_tok_pkg::TT_CLOSE);
    end else if (c == sexp_tok_pkg::CH_SEMI) begin
      pm_mode = sexp_tok_pkg::MODE_COMMENT;
    end else if (c == sexp_tok_pkg::CH_HASH) begin
      put_char(sexp_tok_pkg::TT_BOOL, c);
      pm_mode = sexp_tok_pkg::MODE_HASH;
    end else if (digit_char(c)) begin
      pm_neg = 1'b0;
      pm_dot = 1'b0;
      pm_acc = 64'h0;
      pm_sat = 1'b0;
      acc_digit(c);
      put_char(sexp_tok_pkg::TT_INT, c);
      pm_mode = sexp_tok_pkg::MODE_NUM;
    end else if (c == sexp_tok_pkg::CH_PLUS || c == sexp_tok_pkg::CH_MINUS) begin
      pm_sign = c;
      pm_neg = (c == sexp_tok_pkg::CH_MINUS);
      pm_dot = 1'b0;
      pm_acc = 64'h0;
      pm_sat = 1'b0;
      pm_mode = sexp_tok_pkg::MODE_SIGN;
    end else if (c == sexp_tok_pkg::CH_DOT) begin
      put_char(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_ZERO);
      put_char(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_DOT);
      pm_mode = sexp_tok_pkg::MODE_DOT;
    end else if (c == sexp_tok_pkg::CH_QUOTE) begin
      put_char(sexp_tok_pkg::TT_STR, c);
      pm_mode = sexp_tok_pkg::MODE_STR;
    end else if (c == sexp_tok_pkg::CH_SPACE || c == sexp_tok_pkg::CH_LF ||
                 c == sexp_tok_pkg::CH_TAB) begin
      // whitespace between tokens
    end else if (sym_head(c)) begin
      put_char(sexp_tok_pkg::TT_SYM, c);
      pm_mode = sexp_tok_pkg::MODE_SYM;
    end else begin
      raise_err(sexp_tok_pkg::ERR_ILLEGAL);
    end
  endfunction

  function automatic void step_byte(logic [7:0] c);
    case (pm_mode)
      sexp_tok_pkg::MODE_IDLE: idle_byte(c);
      sexp_tok_pkg::MODE_COMMENT: if (c == sexp_tok_pkg::CH_LF) pm_mode = sexp_tok_pkg::MODE_IDLE;
      sexp_tok_pkg::MODE_HASH: begin
        if (c == "t" || c == "T") begin
          put_char(sexp_tok_pkg::TT_BOOL, c);
          emit_word(sexp_tok_pkg::KIND_END, sexp_tok_pkg::TT_BOOL, 8'h00, 1'b1, 32'h0, 1'b0,
                    sexp_tok_pkg::ERR_NONE);
          pm_mode = sexp_tok_pkg::MODE_IDLE;
        end else if (c == "f" || c == "F") begin
          put_char(sexp_tok_pkg::TT_BOOL, c);
          put_end(sexp_tok_pkg::TT_BOOL);
          pm_mode = sexp_tok_pkg::MODE_IDLE;
        end else begin
          raise_err(sexp_tok_pkg::ERR_BOOL);
        end
      end
      sexp_tok_pkg::MODE_SIGN: begin
        if (c == sexp_tok_pkg::CH_SPACE) begin
          put_char(sexp_tok_pkg::TT_SYM, pm_sign);
          put_end(sexp_tok_pkg::TT_SYM);
          pm_mode = sexp_tok_pkg::MODE_IDLE;
        end else if (digit_char(c)) begin
          // a plus sign is not kept in the text
          if (pm_neg) put_char(sexp_tok_pkg::TT_INT, sexp_tok_pkg::CH_MINUS);
          acc_digit(c);
          put_char(sexp_tok_pkg::TT_INT, c);
          pm_mode = sexp_tok_pkg::MODE_NUM;
        end else if (c == sexp_tok_pkg::CH_DOT) begin
          if (pm_neg) put_char(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_MINUS);
          put_char(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_ZERO);
          put_char(sexp_tok_pkg::TT_FLOAT, sexp_tok_pkg::CH_DOT);
          pm_mode = sexp_tok_pkg::MODE_DOT;
        end else begin
          raise_err(sexp_tok_pkg::ERR_SIGN);
        end
      end
      sexp_tok_pkg::MODE_NUM: begin
        if (digit_char(c)) begin
          if (!pm_dot) acc_digit(c);
          put_char(pm_dot ? sexp_tok_pkg::TT_FLOAT : sexp_tok_pkg::TT_INT, c);
        end else if (c == sexp_tok_pkg::CH_DOT) begin
          if (pm_dot) begin
            raise_err(sexp_tok_pkg::ERR_DOT2);
          end else begin
            pm_dot = 1'b1;
            put_char(sexp_tok_pkg::TT_FLOAT, c);
          end
        end else if (c == sexp_tok_pkg::CH_SPACE) begin
          close_number();
        end else if (c == sexp_tok_pkg::CH_RPAREN) begin
          close_number();
          idle_byte(c);
        end else begin
          raise_err(sexp_tok_pkg::ERR_NUM_CHAR);
        end
      end
      sexp_tok_pkg::MODE_DOT: begin
        if (digit_char(c)) begin
          put_char(sexp_tok_pkg::TT_FLOAT, c);
          pm_mode = sexp_tok_pkg::MODE_FRAC;
        end else begin
          raise_err(sexp_tok_pkg::ERR_DOT);
        end
      end
      sexp_tok_pkg::MODE_FRAC: begin
        if (digit_char(c)) begin
          put_char(sexp_tok_pkg::TT_FLOAT, c);
        end else if (c == sexp_tok_pkg::CH_SPACE) begin
          put_end(sexp_tok_pkg::TT_FLOAT);
          pm_mode = sexp_tok_pkg::MODE_IDLE;
        end else if (c == sexp_tok_pkg::CH_RPAREN) begin
          put_end(sexp_tok_pkg::TT_FLOAT);
          idle_byte(c);
        end else begin
          raise_err(sexp_tok_pkg::ERR_FLOAT);
        end
      end
      sexp_tok_pkg::MODE_STR: begin
        put_char(sexp_tok_pkg::TT_STR, c);
        if (c == sexp_tok_pkg::CH_BSLASH) begin
          pm_mode = sexp_tok_pkg::MODE_ESC;
        end else if (c == sexp_tok_pkg::CH_QUOTE) begin
          put_end(sexp_tok_pkg::TT_STR);
          pm_mode = sexp_tok_pkg::MODE_IDLE;
        end
      end
      sexp_tok_pkg::MODE_ESC: begin
        put_char(sexp_tok_pkg::TT_STR, c);
        pm_mode = sexp_tok_pkg::MODE_STR;
      end
      sexp_tok_pkg::MODE_SYM: begin
        if (sym_tail(c)) begin
          put_char(sexp_tok_pkg::TT_SYM, c);
        end else if (c == sexp_tok_pkg::CH_SPACE || c == sexp_tok_pkg::CH_LPAREN ||
                     c == sexp_tok_pkg::CH_RPAREN) begin
          put_end(sexp_tok_pkg::TT_SYM);
          idle_byte(c);
        end else begin
          raise_err(sexp_tok_pkg::ERR_SYM_END);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void tokenize_byte(logic [7:0] c, logic eoi);
    step_words.delete();
    if (eoi) begin
      case (pm_mode)
        sexp_tok_pkg::MODE_HASH: raise_err(sexp_tok_pkg::ERR_BOOL);
        sexp_tok_pkg::MODE_SIGN: raise_err(sexp_tok_pkg::ERR_SIGN);
        sexp_tok_pkg::MODE_NUM:  raise_err(sexp_tok_pkg::ERR_NUM_CHAR);
        sexp_tok_pkg::MODE_DOT:  raise_err(sexp_tok_pkg::ERR_DOT);
        sexp_tok_pkg::MODE_FRAC: raise_err(sexp_tok_pkg::ERR_FLOAT);
        sexp_tok_pkg::MODE_STR, sexp_tok_pkg::MODE_ESC: raise_err(sexp_tok_pkg::ERR_STR);
        sexp_tok_pkg::MODE_SYM:  raise_err(sexp_tok_pkg::ERR_SYM_END);
        default: ;
      endcase
      emit_word(sexp_tok_pkg::KIND_EOS, sexp_tok_pkg::TT_OPEN, 8'h00, 1'b0, 32'h0, 1'b0,
                sexp_tok_pkg::ERR_NONE);
      clear_lexer();
    end else begin
      step_byte(c);
    end
    if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_events.push_back(step_words[i]);
  endfunction

  initial clear_lexer();

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    fail_count++;
    $display("mismatch on %s at word %0d: expected %0h, got %0h", what, words_seen, exp_v,
             got_v);
  endtask

  always @(posedge clk) begin : monitor
    tok_word_t w;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        words_seen <= words_seen + 1;
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected word, kind", 32'h0, 32'(out_if.kind));
        end else begin
          w = expected_events.pop_front();
          if (out_if.kind !== w.kind)
            report_mismatch("kind", 32'(w.kind), 32'(out_if.kind));
          if (out_if.token_type !== w.tt)
            report_mismatch("token_type", 32'(w.tt), 32'(out_if.token_type));
          if (out_if.text_char !== w.ch)
            report_mismatch("text_char", 32'(w.ch), 32'(out_if.text_char));
          if (out_if.bool_value !== w.bv)
            report_mismatch("bool_value", 32'(w.bv), 32'(out_if.bool_value));
          if (out_if.int_value !== w.iv) report_mismatch("int_value", w.iv, out_if.int_value);
          if (out_if.int_overflow !== w.ov)
            report_mismatch("int_overflow", 32'(w.ov), 32'(out_if.int_overflow));
          if (out_if.error_code !== w.err)
            report_mismatch("error_code", 32'(w.err), 32'(out_if.error_code));
          if (out_if.last !== w.last)
            report_mismatch("last", 32'(w.last), 32'(out_if.last));
        end
      end
      if (in_if.valid && in_if.ready) tokenize_byte(in_if.char_in, in_if.end_of_input);
    end
  end

  // ---------------------------------------------------------------- driving

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.char_in <= 8'h00;
      in_if.end_of_input <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_if.valid && in_if.ready) void'(source_bytes.pop_front());
      if (in_if.valid && !in_if.ready) begin
        // word still on offer
      end else if (send_gap > 0) begin
        in_if.valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (source_bytes.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        in_if.valid <= 1'b0;
        send_gap <= $urandom_range(0, 5);
      end else begin
        in_if.valid <= 1'b1;
        in_if.char_in <= source_bytes[0].c;
        in_if.end_of_input <= source_bytes[0].eoi;
      end
    end
  end

  // result side: random stalls plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      recv_stall <= 0;
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else if (long_hold_left > 0) begin
      out_if.ready <= 1'b0;
      long_hold_left <= long_hold_left - 1;
    end else if (!long_hold_done && words_seen >= 120) begin
      out_if.ready <= 1'b0;
      long_hold_done <= 1'b1;
      long_hold_left <= 79;
    end else if (recv_stall > 0) begin
      out_if.ready <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_if.ready <= 1'b0;
      recv_stall <= $urandom_range(0, 5);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(logic [7:0] c);
    source_bytes.push_back({1'b0, c});
    queued_items++;
  endtask

  task automatic push_eoi();
    source_bytes.push_back({1'b1, 8'(($urandom_range(0, 255)))});
    queued_items++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_digits(int n);
    repeat (n) push_byte(sexp_tok_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  function automatic logic [7:0] pick_sym_head();
    string marks;
    marks = "!$%&*/:<>=?~_^";
    case ($urandom_range(0, 2))
      0: return 8'h61 + 8'($urandom_range(0, 25));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      default: return marks[$urandom_range(0, marks.len() - 1)];
    endcase
  endfunction

  // token separator; anything but space or close paren is followed by end of input
  task automatic push_sep();
    int r;
    r = $urandom_range(0, 99);
    if (r < 76) begin
      push_byte(sexp_tok_pkg::CH_SPACE);
    end else if (r < 88) begin
      push_byte(sexp_tok_pkg::CH_RPAREN);
    end else begin
      if (r < 92) push_byte(sexp_tok_pkg::CH_LPAREN);
      else if (r < 95) push_byte(sexp_tok_pkg::CH_TAB);
      else if (r < 98) push_byte(sexp_tok_pkg::CH_LF);
      push_eoi();
    end
  endtask

  task automatic queue_token();
    int r;
    int n;
    logic [7:0] b;
    string flags;
    flags = "tTfF";
    r = $urandom_range(0, 99);
    if (r < 10) begin
      push_byte(sexp_tok_pkg::CH_LPAREN);
    end else if (r < 20) begin
      push_byte(sexp_tok_pkg::CH_RPAREN);
    end else if (r < 28) begin
      push_byte(sexp_tok_pkg::CH_HASH);
      if ($urandom_range(0, 9) == 0) begin
        push_byte(8'($urandom_range(0, 255)));
        push_eoi();
      end else begin
        push_byte(flags[$urandom_range(0, 3)]);
      end
    end else if (r < 48) begin
      n = $urandom_range(0, 9);
      if (n < 3) push_byte(sexp_tok_pkg::CH_MINUS);
      else if (n < 5) push_byte(sexp_tok_pkg::CH_PLUS);
      // values around the saturation limits
      case ($urandom_range(0, 9))
        0: push_text("2147483647");
        1: push_text("2147483648");
        2: push_text("2147483649");
        3: push_text("99999999999");
        default: push_digits($urandom_range(1, 5));
      endcase
      push_sep();
    end else if (r < 60) begin
      case ($urandom_range(0, 4))
        0: begin
          push_digits($urandom_range(1, 3));
          push_byte(sexp_tok_pkg::CH_DOT);
          push_digits($urandom_range(0, 3));
        end
        1: begin
          push_byte(sexp_tok_pkg::CH_DOT);
          push_digits($urandom_range(1, 3));
        end
        2: begin
          push_byte($urandom_range(0, 1) ? sexp_tok_pkg::CH_PLUS : sexp_tok_pkg::CH_MINUS);
          push_byte(sexp_tok_pkg::CH_DOT);
          push_digits($urandom_range(1, 3));
        end
        3: begin
          push_byte(sexp_tok_pkg::CH_MINUS);
          push_digits($urandom_range(1, 2));
          push_byte(sexp_tok_pkg::CH_DOT);
          push_digits($urandom_range(1, 2));
        end
        default: begin
          // second dot
          push_digits($urandom_range(1, 2));
          push_byte(sexp_tok_pkg::CH_DOT);
          push_digits($urandom_range(0, 2));
          push_byte(sexp_tok_pkg::CH_DOT);
          push_eoi();
        end
      endcase
      push_sep();
    end else if (r < 70) begin
      push_byte(sexp_tok_pkg::CH_QUOTE);
      repeat ($urandom_range(0, 8)) begin
        if ($urandom_range(0, 99) < 15) begin
          push_byte(sexp_tok_pkg::CH_BSLASH);
          push_byte(8'($urandom_range(0, 255)));
        end else begin
          b = 8'($urandom_range(0, 255));
          if (b == sexp_tok_pkg::CH_QUOTE || b == sexp_tok_pkg::CH_BSLASH) b = "q";
          push_byte(b);
        end
      end
      push_byte(sexp_tok_pkg::CH_QUOTE);
    end else if (r < 84) begin
      push_byte(pick_sym_head());
      repeat ($urandom_range(0, 5)) begin
        case ($urandom_range(0, 5))
          0: push_digits(1);
          1: push_byte(sexp_tok_pkg::CH_DOT);
          2: push_byte(sexp_tok_pkg::CH_PLUS);
          3: push_byte(sexp_tok_pkg::CH_MINUS);
          default: push_byte(pick_sym_head());
        endcase
      end
      push_sep();
    end else if (r < 87) begin
      push_byte($urandom_range(0, 1) ? sexp_tok_pkg::CH_PLUS : sexp_tok_pkg::CH_MINUS);
      push_byte(sexp_tok_pkg::CH_SPACE);
    end else if (r < 91) begin
      push_byte(sexp_tok_pkg::CH_SEMI);
      repeat ($urandom_range(0, 10)) begin
        b = 8'($urandom_range(0, 255));
        if (b == sexp_tok_pkg::CH_LF) b = sexp_tok_pkg::CH_SPACE;
        push_byte(b);
      end
      push_byte(sexp_tok_pkg::CH_LF);
    end else if (r < 96) begin
      // token cut short or broken, then end of input
      case ($urandom_range(0, 16))
        0: push_text("#");
        1: push_text("+");
        2: push_text("-");
        3: push_text(".");
        4: push_text("12");
        5: push_text("3.");
        6: push_text("-.");
        7: push_text("\"ab");
        8: push_text("\"x\\");
        9: push_text("sym");
        10: push_text("-x");
        11: push_text("#q");
        12: push_text(".x");
        13: push_text("1.5x");
        14: push_text("12a");
        15: push_text("ab,");
        default: push_text(".5");
      endcase
      push_eoi();
    end else begin
      push_byte(8'($urandom_range(0, 255)));
      push_eoi();
    end
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((source_bytes.size() != 0 || expected_events.size() != 0) && guard < 20000) begin
      @(negedge clk);
      guard++;
    end
    repeat (4) @(negedge clk);
  endtask

  initial begin : stimulus
    @(negedge clk);
    while (!rst_n) @(negedge clk);

    push_text("(#t -9 +.5 \"\\\"\" a(");
    push_eoi();
    push_byte(8'hFF);
    push_byte(8'h00);
    push_eoi();
    wait_drained();

    while (queued_items < 290) queue_token();
    push_eoi();
    while (source_bytes.size() != 0) @(negedge clk);

    quiet = 1'b1;
    while (queued_items < 330) queue_token();
    push_eoi();
    wait_drained();

    if (expected_events.size() != 0)
      report_mismatch("words never delivered", 32'(expected_events.size()), 32'h0);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/sexp_tok_pkg.sv
rtl/sexp_tok_in_if.sv
rtl/sexp_tok_out_if.sv
rtl/sexp_tok_step.sv
rtl/s_expression_tokenizer_core.sv
verif/s_expression_tokenizer_core_tb.sv
